>>> hw/rtl/gtg_pkg.sv
// Shared types and constants of the go-to-goal controller.
package gtg_pkg;

   localparam int XW = 44;   // CORDIC x/y datapath width
   localparam int ZW = 29;   // CORDIC angle width (rad * 2^24)
   localparam int NumAtan = 24;

   localparam logic signed [ZW-1:0] ANG_HALF_PI = 29'sd26353589;
   localparam logic signed [ZW-1:0] ANG_PI      = 29'sd52707179;
   localparam logic signed [ZW-1:0] ANG_TWO_PI  = 29'sd105414357;
   localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

   localparam logic [2:0] CSR_GOAL_X = 3'd0;
   localparam logic [2:0] CSR_GOAL_Y = 3'd1;
   localparam logic [2:0] CSR_GAIN_LIN = 3'd2;
   localparam logic [2:0] CSR_GAIN_ANG = 3'd3;
   localparam logic [2:0] CSR_TOL = 3'd4;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic signed [15:0]   hd;
      logic                 vld;
   } cell_type;

   function automatic logic signed [ZW-1:0] atan_lookup(input logic [4:0] idx);
      logic signed [ZW-1:0] r;
      case (idx)
         5'd0: r = 29'sd13176795;
         5'd1: r = 29'sd7778716;
         5'd2: r = 29'sd4110060;
         5'd3: r = 29'sd2086331;
         5'd4: r = 29'sd1047214;
         5'd5: r = 29'sd524117;
         5'd6: r = 29'sd262123;
         5'd7: r = 29'sd131069;
         5'd8: r = 29'sd65536;
         5'd9: r = 29'sd32768;
         5'd10: r = 29'sd16384;
         5'd11: r = 29'sd8192;
         5'd12: r = 29'sd4096;
         5'd13: r = 29'sd2048;
         5'd14: r = 29'sd1024;
         5'd15: r = 29'sd512;
         5'd16: r = 29'sd256;
         5'd17: r = 29'sd128;
         5'd18: r = 29'sd64;
         5'd19: r = 29'sd32;
         5'd20: r = 29'sd16;
         5'd21: r = 29'sd8;
         5'd22: r = 29'sd4;
         5'd23: r = 29'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/gtg_cell.sv
// One CORDIC vectoring micro-rotation cell with its pipeline register.
module gtg_cell #(
   parameter int Shift = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  gtg_pkg::cell_type  cell_in,
   output gtg_pkg::cell_type  cell_out
);
   gtg_pkg::cell_type cell_ff, cell_in_w;
   logic signed [gtg_pkg::XW-1:0] xs, ys;

   always_comb begin
      xs = cell_in.x >>> Shift;
      ys = cell_in.y >>> Shift;
      cell_in_w = cell_in;
      if (!cell_in.y[gtg_pkg::XW-1]) begin
         cell_in_w.x = cell_in.x + ys;
         cell_in_w.y = cell_in.y - xs;
         cell_in_w.z = cell_in.z + gtg_pkg::atan_lookup(5'(Shift));
      end else begin
         cell_in_w.x = cell_in.x - ys;
         cell_in_w.y = cell_in.y + xs;
         cell_in_w.z = cell_in.z - gtg_pkg::atan_lookup(5'(Shift));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (adv) begin
         cell_ff.vld <= cell_in.vld;
      end
      if (adv) begin
         cell_ff.x  <= cell_in_w.x;
         cell_ff.y  <= cell_in_w.y;
         cell_ff.z  <= cell_in_w.z;
         cell_ff.hd <= cell_in_w.hd;
      end
   end

   assign cell_out = cell_ff;
endmodule

>>> hw/rtl/go_to_goal_unicycle_ctrl.sv
// Top level of the pipelined go-to-goal unicycle controller.
// Channels: req_ carries one pose per request (tdata = pos_x, pos_y, heading
// from bit 0 up); rsp_ returns one command per request (tdata = linear_speed,
// turn_rate; tuser = goal_reached, saturated). csr_ writes the goal, gains
// and tolerance; write only while idle.
// Throughput: one request per cycle while the output is not stalled. Stages:
// one entry stage with the quadrant pre-rotation, one cell per CORDIC
// micro-rotation, then gain removal, distance rounding, one command
// multiplier stage and the output register with rounding and saturation.
// The whole pipe advances together; when rsp_tready is low and the output
// register is full, the pipe freezes and req_tready drops, so nothing is
// lost. Reset empties the pipe and restores the register defaults
// (goal 2.5, 2.5; gains 0.5 and 1.0; tolerance about 0.1).
module go_to_goal_unicycle_ctrl #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pos_x, pos_y, heading
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // linear_speed, turn_rate
   output logic [1:0]  rsp_tuser,   // goal_reached, saturated
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int NS = (CORDIC_STAGES < gtg_pkg::NumAtan) ? CORDIC_STAGES
                                                          : gtg_pkg::NumAtan;
   localparam int XW = gtg_pkg::XW;
   localparam int ZW = gtg_pkg::ZW;

   logic signed [15:0] goal_x_ff, goal_y_ff;
   logic [15:0] gain_lin_ff, gain_ang_ff, tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff   <= 16'sd5120;
         goal_y_ff   <= 16'sd5120;
         gain_lin_ff <= 16'd2048;
         gain_ang_ff <= 16'd4096;
         tol_ff      <= 16'd205;
      end else if (csr_wen) begin
         case (csr_index)
            gtg_pkg::CSR_GOAL_X:   goal_x_ff   <= csr_wdata;
            gtg_pkg::CSR_GOAL_Y:   goal_y_ff   <= csr_wdata;
            gtg_pkg::CSR_GAIN_LIN: gain_lin_ff <= csr_wdata;
            gtg_pkg::CSR_GAIN_ANG: gain_ang_ff <= csr_wdata;
            gtg_pkg::CSR_TOL:      tol_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Entry stage: offsets and quadrant pre-rotation.
   gtg_pkg::cell_type entry_ff, entry_in;
   logic signed [16:0] dx, dy;
   logic signed [XW-1:0] xe, ye;
   always_comb begin
      dx = 17'(goal_x_ff) - 17'($signed(req_tdata[15:0]));
      dy = 17'(goal_y_ff) - 17'($signed(req_tdata[31:16]));
      xe = XW'(dx) <<< 8;
      ye = XW'(dy) <<< 8;
      entry_in.vld = req_tvalid;
      entry_in.hd  = req_tdata[47:32];
      entry_in.x = xe;
      entry_in.y = ye;
      entry_in.z = '0;
      if (xe[XW-1]) begin
         if (!ye[XW-1]) begin
            entry_in.x = ye;
            entry_in.y = -xe;
            entry_in.z = gtg_pkg::ANG_HALF_PI;
         end else begin
            entry_in.x = -ye;
            entry_in.y = xe;
            entry_in.z = -gtg_pkg::ANG_HALF_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.vld <= 1'b0;
      end else if (adv) begin
         entry_ff.vld <= entry_in.vld;
      end
      if (adv) begin
         entry_ff.x  <= entry_in.x;
         entry_ff.y  <= entry_in.y;
         entry_ff.z  <= entry_in.z;
         entry_ff.hd <= entry_in.hd;
      end
   end

   gtg_pkg::cell_type chain [NS+1];
   assign chain[0] = entry_ff;

   for (genvar i = 0; i < NS; i++) begin : g_cell
      gtg_cell #(.Shift(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   gtg_pkg::cell_type fin;
   assign fin = chain[NS];

   // Stage A: gain removal product and angle error with wrap.
   logic signed [XW+17:0] prod_ff, prod_in;
   logic signed [ZW:0] err_ff, err_in, e0;
   logic va_ff;
   always_comb begin
      prod_in = (XW+18)'(fin.x) * $signed({1'b0, gtg_pkg::INV_GAIN_Q16})
              + (XW+18)'(64'sd8388608);
      e0 = ((ZW+1)'(fin.hd) <<< 11) - (ZW+1)'(fin.z);
      err_in = e0;
      if (e0 > (ZW+1)'(gtg_pkg::ANG_PI)) begin
         err_in = e0 - (ZW+1)'(gtg_pkg::ANG_TWO_PI);
      end else if (e0 < -(ZW+1)'(gtg_pkg::ANG_PI)) begin
         err_in = e0 + (ZW+1)'(gtg_pkg::ANG_TWO_PI);
      end
   end

   // Stage B: distance shift, clamped at zero.
   logic signed [XW+17:0] dsh;
   logic [XW-7:0] d_in;
   logic [XW-7:0] d_ff;
   logic [ZW:0] err_b_ff;
   logic vb_ff;
   always_comb begin
      dsh = prod_ff >>> 24;
      d_in = dsh[XW+17] ? '0 : dsh[XW-7:0];
   end

   // Stage C: reach test and command multiplications.
   logic [16:0] d17;
   logic d_big;
   logic signed [34:0] lin_p_ff, lin_p_in;
   logic signed [47:0] turn_p_ff, turn_p_in;
   logic reached_ff, reached_in, vc_ff;
   always_comb begin
      d_big = |d_ff[XW-7:17];
      d17 = d_ff[16:0];
      reached_in = !d_big && (d17 <= {1'b0, tol_ff});
      lin_p_in = $signed({1'b0, gain_lin_ff}) * $signed({1'b0, d17});
      turn_p_in = -($signed({1'b0, gain_ang_ff}) * 48'($signed(err_b_ff)));
   end
   logic d_big_ff;

   // Stage D: rounding, saturation, output register.
   logic signed [35:0] lin_r;
   logic signed [48:0] turn_r;
   logic [15:0] lin_o, turn_o;
   logic clip_l, clip_t;
   always_comb begin
      lin_r = (36'(lin_p_ff) + 36'sd2048) >>> 12;
      turn_r = (49'(turn_p_ff) + 49'sd16777216) >>> 25;
      clip_l = d_big_ff || (lin_r > 36'sd32767);
      lin_o = clip_l ? 16'h7fff : lin_r[15:0];
      clip_t = 1'b1;
      if (turn_r > 49'sd32767) begin
         turn_o = 16'h7fff;
      end else if (turn_r < -49'sd32768) begin
         turn_o = 16'h8000;
      end else begin
         turn_o = turn_r[15:0];
         clip_t = 1'b0;
      end
      if (reached_ff) begin
         lin_o = '0;
         turn_o = '0;
         clip_l = 1'b0;
         clip_t = 1'b0;
      end
   end

   logic rsp_vld_ff;
   logic [31:0] rsp_data_ff;
   logic [1:0] rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= fin.vld;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         rsp_vld_ff <= vc_ff;
      end
      if (adv) begin
         prod_ff <= prod_in;
         err_ff <= err_in;
         d_ff <= d_in;
         err_b_ff <= err_ff;
         lin_p_ff <= lin_p_in;
         turn_p_ff <= turn_p_in;
         reached_ff <= reached_in;
         d_big_ff <= d_big;
         rsp_data_ff <= {turn_o, lin_o};
         rsp_user_ff <= {clip_l || clip_t, reached_ff};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
endmodule
